// File: hdl/assert_macros.svh
// Assertion macros shared by the link core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hdl/ptsl_pkg.sv
// Package: constants and payload types of the paper tape station link
package ptsl_pkg;
  localparam int TapeAw = 16;
  localparam int TapeDepth = 1 << TapeAw;
  localparam int RingAw = 5;

  localparam logic [2:0] CmdNet = 3'd0;
  localparam logic [2:0] CmdF71 = 3'd1;
  localparam logic [2:0] CmdF74 = 3'd2;
  localparam logic [2:0] CmdAct = 3'd3;
  localparam logic [2:0] CmdClines = 3'd4;

  localparam logic [7:0] NetReset = 8'h80;
  localparam logic [7:0] NetBlock = 8'h81;
  localparam logic [7:0] NetRewind = 8'h82;
  localparam logic [7:0] NetEchoOn = 8'h84;
  localparam logic [7:0] NetEchoOff = 8'h85;
  localparam logic [7:0] NetOnlOn = 8'h88;
  localparam logic [7:0] NetOnlOff = 8'h89;
  localparam logic [7:0] NetOnlChar = 8'h8A;
  localparam logic [7:0] AckByte = 8'h81;
  localparam logic [5:0] ShiftBase = 6'h1B;
  localparam logic [15:0] BusyReset = 16'd347;

  typedef enum logic [4:0] {
    PsIdle = 5'b00001,
    PsResetArgs = 5'b00010,
    PsBlockLen = 5'b00100,
    PsBlockData = 5'b01000,
    PsOnlChar = 5'b10000
  } ps_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] rx_byte;
    logic level;
    logic [12:0] clines;
    logic [31:0] word_time;
  } in_t;

  typedef struct packed {
    logic ready_valid;
    logic ready_level;
    logic trlines_valid;
    logic [4:0] trlines_value;
    logic tx_valid;
    logic [7:0] tx_byte;
    logic last;
  } out_t;
endpackage

// File: hdl/ptsl_if.sv
// Valid/ready channel interfaces for requests and results
interface ptsl_in_if;
  import ptsl_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic [7:0] rx_byte;
  logic level;
  logic [12:0] clines;
  logic [31:0] word_time;
  modport source(output valid, command, rx_byte, level, clines, word_time, input ready);
  modport sink(input valid, command, rx_byte, level, clines, word_time, output ready);
endinterface

interface ptsl_out_if;
  logic valid;
  logic ready;
  logic ready_valid;
  logic ready_level;
  logic trlines_valid;
  logic [4:0] trlines_value;
  logic tx_valid;
  logic [7:0] tx_byte;
  logic last;
  modport source(output valid, ready_valid, ready_level, trlines_valid, trlines_value,
                 tx_valid, tx_byte, last, input ready);
  modport sink(input valid, ready_valid, ready_level, trlines_valid, trlines_value,
               tx_valid, tx_byte, last, output ready);
endinterface

// File: hdl/ptsl_outq.sv
// Eight-entry result queue with up to three pushes per cycle
`include "assert_macros.svh"
module ptsl_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push0_i,
  input  ptsl_pkg::out_t    data0_i,
  input  logic              push1_i,
  input  ptsl_pkg::out_t    data1_i,
  input  logic              push2_i,
  input  ptsl_pkg::out_t    data2_i,
  output logic              room_o,
  output logic              valid_o,
  output ptsl_pkg::out_t    data_o,
  input  logic              ready_i
);
  import ptsl_pkg::*;
  out_t mem_q [8];
  logic [2:0] wp_q, rp_q;
  logic [2:0] wp1, wp2;
  logic [3:0] cnt_q;
  logic [1:0] npush;
  logic pop;

  assign pop = valid_o && ready_i;
  assign valid_o = cnt_q != 4'd0;
  assign data_o = mem_q[rp_q];
  assign npush = 2'(push0_i) + 2'(push1_i) + 2'(push2_i);
  // pack the pushes of one cycle into consecutive slots
  assign wp1 = wp_q + 3'(push0_i);
  assign wp2 = wp1 + 3'(push1_i);
  // keep room for a pending reader result and two results of the next request
  assign room_o = cnt_q <= 4'd4;

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wp_q] <= data0_i;
    if (push1_i) mem_q[wp1] <= data1_i;
    if (push2_i) mem_q[wp2] <= data2_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + 3'(npush);
      if (pop) rp_q <= rp_q + 3'd1;
      cnt_q <= cnt_q + 4'(npush) - 4'(pop);
    end
  end

  `ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 4'd8)
  `ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, 1'b1, 5'(cnt_q) + 5'(npush) <= 5'd8)
  `ASSERT_IMPLIES(a_push_order, clk_i, rst_ni, push2_i, push1_i)
endmodule

// File: hdl/paper_tape_station_link_core.sv
// Top level: paper tape station link with tape and ring memories
//  channel | dir | handshake   | payload
//  req_if  | in  | valid/ready | command, rx_byte, level, clines, word_time
//  res_if  | out | valid/ready | ready/trlines/tx fields, last
//  cfg     | in  | we only     | punch_busy_time
// One request per cycle. A reader request reads the tape or ring memory at
// accept and pushes its result the next cycle, ahead of that cycle's results.
// Up to three results enter the eight-entry result queue in one cycle; a result
// can leave at the earliest in the cycle after its push.
// No clearing pass after reset. Requests stall while the queue holds more than four.
`include "assert_macros.svh"
module paper_tape_station_link_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ptsl_in_if.sink     req_if,
  ptsl_out_if.source  res_if
);
  import ptsl_pkg::*;

  logic [7:0] tape_mem [TapeDepth];
  logic [5:0] ring_mem [1 << RingAw];
  logic [7:0] tape_rd_q;
  logic [5:0] ring_rd_q;

  logic [15:0] busy_time_q;
  ps_e ps_q;
  logic [8:0] rem_q;
  logic [16:0] fill_q, len_q, pos_q;
  logic [RingAw-1:0] rri_q, rwi_q;
  logic shift_q, rsel_q, psel_q, echo_q, onl_q;
  logic [5:0] rchar_q;
  logic [12:0] cl_q;
  logic [31:0] busy_q;
  // pending reader result (data arrives from memory)
  logic rd_pend_q, rd_ring_q, rd_zero_q;

  logic acc, room;
  logic [5:0] rchar_cur;
  logic [7:0] b;
  logic shift;
  logic [RingAw-1:0] rwi_next;
  logic rd_ring_hit, rd_zero_hit, rd_tape_hit, rd_start;
  out_t pend_r, req_r0, req_r1;
  logic req_p0, req_p1;
  out_t res_data;
  logic res_valid;

  assign req_if.ready = room;
  assign acc = req_if.valid && room;
  assign b = req_if.rx_byte;
  assign rchar_cur = rd_pend_q ? (rd_zero_q ? 6'd0 : (rd_ring_q ? ring_rd_q : tape_rd_q[5:0]))
                               : rchar_q;
  assign shift = b[7] || (!b[6] && (b[5] != shift_q));
  assign rwi_next = rwi_q + RingAw'(1);

  assign rd_ring_hit = onl_q && (rri_q != rwi_q);
  assign rd_zero_hit = onl_q && (rri_q == rwi_q) && cl_q[12];
  assign rd_tape_hit = !onl_q && (pos_q < len_q);
  assign rd_start = acc && req_if.command == CmdF71 && req_if.level &&
                    (rd_ring_hit || rd_zero_hit || rd_tape_hit);

  always_ff @(posedge clk_i) begin
    if (acc && req_if.command == CmdNet && ps_q == PsBlockData && !fill_q[16])
      tape_mem[fill_q[TapeAw-1:0]] <= b;
    tape_rd_q <= tape_mem[pos_q[TapeAw-1:0]];
    if (acc && req_if.command == CmdNet && ps_q == PsOnlChar) begin
      if (shift) begin
        ring_mem[rwi_q] <= ShiftBase + {3'd0, b[5], 2'd0};
        ring_mem[rwi_next] <= b[5:0];
      end else begin
        ring_mem[rwi_q] <= b[5:0];
      end
    end
    ring_rd_q <= ring_mem[rri_q];
  end

  always_comb begin
    pend_r = '0;
    pend_r.ready_valid = 1'b1;
    pend_r.ready_level = 1'b1;
    pend_r.last = 1'b1;
  end

  always_comb begin
    req_r0 = '0; req_r1 = '0; req_p0 = 1'b0; req_p1 = 1'b0;
    if (acc) begin
      case (req_if.command)
        CmdNet: begin
          if ((ps_q == PsResetArgs || ps_q == PsBlockData) && rem_q <= 9'd1) begin
            req_p0 = 1'b1;
            req_r0.tx_valid = 1'b1;
            req_r0.tx_byte = AckByte;
            req_r0.last = 1'b1;
          end
        end
        CmdF74: begin
          if (req_if.level && req_if.word_time >= busy_q) begin
            req_p0 = 1'b1;
            req_r0.ready_valid = 1'b1;
            req_r0.ready_level = 1'b1;
            req_r0.last = 1'b1;
          end
        end
        CmdAct: begin
          if (!req_if.level) begin
            req_p0 = rsel_q;
            req_r0.trlines_valid = rsel_q;
            req_r0.last = rsel_q;
          end else if (rsel_q) begin
            req_p0 = 1'b1;
            req_r0.ready_valid = 1'b1;
            req_r0.trlines_valid = 1'b1;
            req_r0.trlines_value = rchar_cur[4:0];
            req_r0.tx_valid = echo_q;
            req_r0.tx_byte = echo_q ? {2'b01, rchar_cur} : 8'd0;
            req_r0.last = !psel_q;
            req_p1 = psel_q;
            req_r1.ready_valid = psel_q;
            req_r1.tx_valid = psel_q;
            req_r1.tx_byte = psel_q ? {3'd0, cl_q[4:0]} : 8'd0;
            req_r1.last = psel_q;
          end else if (psel_q) begin
            req_p0 = 1'b1;
            req_r0.ready_valid = 1'b1;
            req_r0.tx_valid = 1'b1;
            req_r0.tx_byte = {3'd0, cl_q[4:0]};
            req_r0.last = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // pending reader result goes first, then the results of this cycle's request
  ptsl_outq u_outq (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push0_i(rd_pend_q), .data0_i(pend_r),
    .push1_i(req_p0), .data1_i(req_r0),
    .push2_i(req_p1), .data2_i(req_r1),
    .room_o(room), .valid_o(res_valid), .data_o(res_data), .ready_i(res_if.ready)
  );

  assign res_if.valid = res_valid;
  assign {res_if.ready_valid, res_if.ready_level, res_if.trlines_valid,
          res_if.trlines_value, res_if.tx_valid, res_if.tx_byte, res_if.last} = res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_time_q <= BusyReset;
      ps_q <= PsIdle; rem_q <= '0;
      fill_q <= '0; len_q <= '0; pos_q <= '0;
      rri_q <= '0; rwi_q <= '0; shift_q <= 1'b0;
      rsel_q <= 1'b0; psel_q <= 1'b0; echo_q <= 1'b0; onl_q <= 1'b0;
      rchar_q <= '0; cl_q <= '0; busy_q <= '0;
      rd_pend_q <= 1'b0; rd_ring_q <= 1'b0; rd_zero_q <= 1'b0;
    end else begin
      if (cfg_we_i) busy_time_q <= cfg_wdata_i;
      if (rd_pend_q) rchar_q <= rchar_cur;
      rd_pend_q <= rd_start;
      if (acc) begin
        case (req_if.command)
          CmdNet: begin
            case (ps_q)
              PsIdle: begin
                case (b)
                  NetReset: begin ps_q <= PsResetArgs; rem_q <= 9'd2; end
                  NetBlock: ps_q <= PsBlockLen;
                  NetRewind: begin pos_q <= '0; len_q <= fill_q; end
                  NetEchoOn: echo_q <= 1'b1;
                  NetEchoOff: echo_q <= 1'b0;
                  NetOnlOn: onl_q <= 1'b1;
                  NetOnlOff: onl_q <= 1'b0;
                  NetOnlChar: ps_q <= PsOnlChar;
                  default: ;
                endcase
              end
              PsResetArgs: begin
                if (rem_q > 9'd1) rem_q <= rem_q - 9'd1;
                else begin rem_q <= '0; ps_q <= PsIdle; fill_q <= '0; end
              end
              PsBlockLen: begin
                rem_q <= (b == 8'd0) ? 9'd256 : {1'b0, b};
                ps_q <= PsBlockData;
              end
              PsBlockData: begin
                if (!fill_q[16]) fill_q <= fill_q + 17'd1;
                if (rem_q > 9'd1) rem_q <= rem_q - 9'd1;
                else begin rem_q <= '0; ps_q <= PsIdle; end
              end
              PsOnlChar: begin
                if (shift) begin
                  shift_q <= b[5];
                  rwi_q <= rwi_q + RingAw'(2);
                end else rwi_q <= rwi_next;
                ps_q <= PsIdle;
              end
              default: begin ps_q <= PsIdle; rem_q <= '0; end
            endcase
          end
          CmdF71: begin
            rsel_q <= req_if.level;
            if (req_if.level) begin
              rd_ring_q <= rd_ring_hit;
              rd_zero_q <= rd_zero_hit;
              if (rd_ring_hit) rri_q <= rri_q + RingAw'(1);
              if (rd_tape_hit) pos_q <= pos_q + 17'd1;
            end
          end
          CmdF74: begin
            psel_q <= req_if.level;
            if (req_if.level && req_if.word_time >= busy_q)
              busy_q <= req_if.word_time + {16'd0, busy_time_q};
          end
          CmdClines: cl_q <= req_if.clines;
          default: ;
        endcase
      end
    end
  end

  `ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= 17'(TapeDepth))
  `ASSERT_IMPLIES(a_pos_bound, clk_i, rst_ni, 1'b1, pos_q <= len_q)
  `ASSERT_NEXT(a_pend_push, clk_i, rst_ni, rd_pend_q, res_valid)
endmodule

// File: sim/tb_ifs.sv
// Testbench-side note: channel interfaces come from the RTL; this file holds result helpers
`timescale 1ns / 100ps
package tb_ptsl_pkg;
  import ptsl_pkg::*;

  // Expected result of one accepted request, as seen on the result channel.
  typedef struct packed {
    logic       ready_valid;
    logic       ready_level;
    logic       trlines_valid;
    logic [4:0] trlines_value;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } link_res_t;

  class link_scoreboard;
    link_res_t pending[$];
    int errors;
    int checked;

    logic [7:0]  tape[int];
    logic [16:0] fill, tlen, tpos;
    logic [5:0]  ring[32];
    logic [4:0]  rd_ix, wr_ix;
    logic        shift_bit;
    ps_e         pstate;
    logic [8:0]  remain;
    logic        rsel, psel;
    logic [5:0]  rchar;
    logic [12:0] clatch;
    logic [31:0] busy_until;
    logic        echo_on, online;
    logic [15:0] busy_time;

    function new();
      errors = 0;
      checked = 0;
      fill = 0; tlen = 0; tpos = 0;
      rd_ix = 0; wr_ix = 0; shift_bit = 0;
      pstate = PsIdle; remain = 0;
      rsel = 0; psel = 0; rchar = 0; clatch = 0;
      busy_until = 0; echo_on = 0; online = 0;
      busy_time = BusyReset;
      foreach (ring[i]) ring[i] = 0;
    endfunction

    function void set_busy_time(logic [15:0] v);
      busy_time = v;
    endfunction

    function void push_ring(logic [5:0] v);
      ring[wr_ix] = v;
      wr_ix = wr_ix + 5'd1;
    endfunction

    function link_res_t mk(logic rv, logic rl, logic tv, logic [4:0] tval,
                           logic xv, logic [7:0] xb);
      link_res_t r;
      r = '{rv, rl, tv, tval, xv, xb, 1'b0};
      return r;
    endfunction

    function void net_byte(logic [7:0] b, ref link_res_t out[$]);
      logic sh;
      case (pstate)
        PsIdle: begin
          case (b)
            NetReset: begin pstate = PsResetArgs; remain = 2; end
            NetBlock: pstate = PsBlockLen;
            NetRewind: begin tpos = 0; tlen = fill; end
            NetEchoOn: echo_on = 1;
            NetEchoOff: echo_on = 0;
            NetOnlOn: online = 1;
            NetOnlOff: online = 0;
            NetOnlChar: pstate = PsOnlChar;
            default: ;
          endcase
        end
        PsResetArgs: begin
          if (remain > 1) remain--;
          else begin
            remain = 0; pstate = PsIdle; fill = 0;
            out.push_back(mk(0, 0, 0, 0, 1, AckByte));
          end
        end
        PsBlockLen: begin
          remain = (b == 0) ? 9'd256 : {1'b0, b};
          pstate = PsBlockData;
        end
        PsBlockData: begin
          if (fill < TapeDepth) begin
            tape[fill] = b;
            fill++;
          end
          if (remain > 1) remain--;
          else begin
            remain = 0; pstate = PsIdle;
            out.push_back(mk(0, 0, 0, 0, 1, AckByte));
          end
        end
        default: begin
          sh = b[7] || (!b[6] && (b[5] != shift_bit));
          if (sh) begin
            push_ring(ShiftBase + {3'b000, b[5], 2'b00});
            shift_bit = b[5];
          end
          push_ring(b[5:0]);
          pstate = PsIdle;
        end
      endcase
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(in_t rq);
      link_res_t out[$];
      case (rq.command)
        CmdNet: net_byte(rq.rx_byte, out);
        CmdF71: begin
          rsel = rq.level;
          if (rq.level) begin
            if (online) begin
              if (rd_ix != wr_ix) begin
                rchar = ring[rd_ix]; rd_ix = rd_ix + 5'd1;
                out.push_back(mk(1, 1, 0, 0, 0, 0));
              end else if (clatch[12]) begin
                rchar = 0;
                out.push_back(mk(1, 1, 0, 0, 0, 0));
              end
            end else if (tpos < tlen && tpos < TapeDepth) begin
              rchar = tape[tpos][5:0]; tpos++;
              out.push_back(mk(1, 1, 0, 0, 0, 0));
            end
          end
        end
        CmdF74: begin
          psel = rq.level;
          if (rq.level && rq.word_time >= busy_until) begin
            busy_until = rq.word_time + {16'd0, busy_time};
            out.push_back(mk(1, 1, 0, 0, 0, 0));
          end
        end
        CmdAct: begin
          if (!rq.level) begin
            if (rsel) out.push_back(mk(0, 0, 1, 0, 0, 0));
          end else begin
            if (rsel)
              out.push_back(mk(1, 0, 1, rchar[4:0], echo_on,
                               echo_on ? {2'b01, rchar} : 8'h00));
            if (psel) out.push_back(mk(1, 0, 0, 0, 1, {3'b000, clatch[4:0]}));
          end
        end
        CmdClines: clatch = rq.clines;
        default: ;
      endcase
      if (out.size() > 0) out[out.size() - 1].last = 1;
      foreach (out[i]) pending.push_back(out[i]);
    endfunction

    function void report(string what);
      $display("mismatch %0d: %s", errors, what);
      errors++;
    endfunction

    function void check_result(link_res_t got);
      link_res_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.ready_valid !== want.ready_valid) report("ready_valid");
      if (got.ready_level !== want.ready_level) report("ready_level");
      if (got.trlines_valid !== want.trlines_valid) report("trlines_valid");
      if (got.trlines_value !== want.trlines_value) report("trlines_value");
      if (got.tx_valid !== want.tx_valid) report("tx_valid");
      if (got.tx_byte !== want.tx_byte) report("tx_byte");
      if (got.last !== want.last) report("last");
    endfunction
  endclass
endpackage

// File: sim/testbench.sv
// Testbench top: drives link requests and checks results against a scoreboard
`timescale 1ns / 100ps
module testbench;
  import ptsl_pkg::*;
  import tb_ptsl_pkg::*;

  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;
  ptsl_in_if req_if ();
  ptsl_out_if res_if ();

  paper_tape_station_link_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_if(req_if.sink), .res_if(res_if.source)
  );

  link_scoreboard sb;
  in_t req_q[$];
  bit  busy_gaps;
  bit  stim_done;
  int  idle_cycles;
  int  n_req = 0;
  int  n_added = 0;
  logic [31:0] wt;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit gap();
    return busy_gaps && ($urandom_range(99) < 29);
  endfunction

  // Request driver: hold valid until the handshake, idle at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 0;
      {req_if.command, req_if.rx_byte, req_if.level, req_if.clines,
       req_if.word_time} <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request({req_if.command, req_if.rx_byte, req_if.level,
                         req_if.clines, req_if.word_time});
        n_req++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_q.size() > 0 && !gap()) begin
          in_t r;
          r = req_q.pop_front();
          req_if.valid <= 1;
          {req_if.command, req_if.rx_byte, req_if.level, req_if.clines,
           req_if.word_time} <= r;
        end else begin
          req_if.valid <= 0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 0;
      idle_cycles <= 0;
    end else begin
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.ready_valid, res_if.ready_level, res_if.trlines_valid,
                         res_if.trlines_value, res_if.tx_valid, res_if.tx_byte,
                         res_if.last});
      res_if.ready <= !gap();
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("timeout, %0d results still expected", sb.pending.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic add(logic [2:0] c, logic [7:0] b, logic lv, logic [12:0] cl);
    in_t r;
    wt = wt + $urandom_range(400);
    r = '{c, b, lv, cl, wt};
    req_q.push_back(r);
    n_added++;
  endtask

  task automatic add_wt(logic [2:0] c, logic lv, logic [31:0] w);
    in_t r;
    r = '{c, 8'($urandom), lv, 13'($urandom), w};
    req_q.push_back(r);
    n_added++;
  endtask

  // Wait until every queued request is accepted and all its results are checked.
  task automatic drain();
    while (n_req < n_added || sb.pending.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_busy(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_busy_time(v);
  endtask

  // One random request or command sequence, mostly well-formed.
  task automatic add_random();
    int k, len;
    k = $urandom_range(99);
    if (k < 12) begin
      add(CmdNet, NetBlock, 0, 0);
      len = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 6);
      add(CmdNet, 8'(len), 0, 0);
      for (int i = 0; i < (len == 0 ? 256 : len); i++) add(CmdNet, 8'($urandom), 0, 0);
    end else if (k < 15) begin
      add(CmdNet, NetReset, 0, 0);
      add(CmdNet, 8'($urandom), 0, 0);
      add(CmdNet, 8'($urandom), 0, 0);
    end else if (k < 20) add(CmdNet, NetRewind, 0, 0);
    else if (k < 24) add(CmdNet, $urandom_range(1) ? NetEchoOn : NetEchoOff, 0, 0);
    else if (k < 28) add(CmdNet, $urandom_range(1) ? NetOnlOn : NetOnlOff, 0, 0);
    else if (k < 38) begin
      add(CmdNet, NetOnlChar, 0, 0);
      add(CmdNet, 8'($urandom), 0, 0);
    end else if (k < 58) add(CmdF71, 8'($urandom), 1'($urandom), 0);
    else if (k < 68) add(CmdF74, 8'($urandom), 1'($urandom), 0);
    else if (k < 88) add(CmdAct, 8'($urandom), 1'($urandom), 0);
    else if (k < 94) add(CmdClines, 0, 0, 13'($urandom));
    else if (k < 97) add(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 13'($urandom));
    else add(CmdNet, 8'($urandom), 0, 0);
  endtask

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    busy_gaps = 1;
    wt = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: tape load, rewind, reader, punch busy, ring, unknown codes.
    add(CmdNet, 8'h00, 0, 0);
    add(CmdNet, 8'hFF, 0, 0);
    add(CmdNet, NetBlock, 0, 0);
    add(CmdNet, 8'd2, 0, 0);
    add(CmdNet, 8'hFF, 0, 0);
    add(CmdNet, 8'h00, 0, 0);
    add(CmdNet, NetRewind, 0, 0);
    add(CmdNet, NetEchoOn, 0, 0);
    add(CmdF71, 0, 1, 0);
    add(CmdF74, 0, 1, 0);
    add(CmdClines, 0, 0, 13'h1FFF);
    add(CmdAct, 0, 1, 0);
    add(CmdAct, 0, 0, 0);
    add_wt(CmdF74, 1, 32'hFFFF_FFFF);
    add(CmdNet, NetOnlOn, 0, 0);
    add(CmdNet, NetOnlChar, 0, 0);
    add(CmdNet, 8'hFF, 0, 0);
    add(CmdF71, 0, 1, 0);
    add(CmdF71, 0, 1, 0);
    add(CmdF71, 0, 1, 0);
    add(CmdF71, 0, 1, 0);
    add(CmdNet, NetReset, 0, 0);
    add(CmdNet, 8'h00, 0, 0);
    add(CmdNet, 8'hFF, 0, 0);
    add(3'd7, 8'hFF, 1, 13'h1FFF);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_busy(16'd0);
        1: write_busy(16'hFFFF);
        2: write_busy(16'($urandom));
        default: write_busy(16'd347);
      endcase
      busy_gaps = (phase != 2);
      while (req_q.size() < 120) add_random();
      drain();
    end
    // Flood the ring past its depth to cover overrun.
    add(CmdNet, NetOnlOn, 0, 0);
    for (int i = 0; i < 40; i++) begin
      add(CmdNet, NetOnlChar, 0, 0);
      add(CmdNet, 8'($urandom), 0, 0);
    end
    for (int i = 0; i < 40; i++) add(CmdF71, 0, 1, 0);
    drain();

    $display("covered %0d requests and %0d results over four punch busy settings",
             n_req, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
